### hdl/vtx_pkg.sv
// Shared constants, types and codes of the vertex transform unit.
`default_nettype none

package vtx_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned RND_W     = ACC_W - FRAC_BITS;
  localparam int unsigned HI_W      = ACC_W + 1 - DATA_W;
  localparam int unsigned QCNT_W    = $clog2(DATA_W);
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned MAT_DEPTH = 16;
  localparam int unsigned MAT_AW    = $clog2(MAT_DEPTH);
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IN_TDATA_W  = ((MAT_AW + 4 * DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((3 * DATA_W + 7) / 8) * 8;
  localparam int unsigned NORM_TOP  = 30;

  localparam logic [1:0] K_BIAS    = 2'd3;
  localparam logic [1:0] LAST_ROW  = 2'd3;
  localparam logic [1:0] LAST_COMP = 2'd2;
  localparam logic [1:0] INV_DIM   = 2'd3;
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(DATA_W - 1);

  localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    MODE_WR_FWD = 2'd0,
    MODE_WR_INV = 2'd1,
    MODE_POINT  = 2'd2,
    MODE_DIR    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHK,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [HI_W-1:0]   hi;
    logic [DATA_W-1:0] lo;
    logic [RND_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

### hdl/vertex_transform_unit.sv
// Vertex transform unit: matrix store, shared MAC, normaliser, square root and divide sequencer.
// Writes are taken while idle. A point: MAC (16 coefficient reads, one 32x32 multiplier), then
// the bit-serial divider per component (an overflowing component saturates without it), then the
// output load; a zero w goes straight to the output. A direction adds normalising, squaring and
// square-root steps, a zero one going straight out. The next word is taken the cycle after the load.
// Reset clears control state; both matrices read as identity until an entry is written.
`default_nettype none

module vertex_transform_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // coef_index, coef_value, in_x, in_y, in_z, zero pad (lowest bit up)
  input  logic [vtx_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // mode
  input  logic [vtx_pkg::MODE_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // out_x, out_y, out_z (lowest bit up)
  output logic [vtx_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // degenerate, saturated (lowest bit up)
  output logic [1:0]                          m_axis_tuser_o
);

  import vtx_pkg::*;

  function automatic logic [RND_W-1:0] mag(input logic signed [RND_W-1:0] v);
    mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
  endfunction

  function automatic logic [DATA_W:0] clamp(input logic signed [RND_W-1:0] v);
    logic fits;
    fits = (v[RND_W-1:DATA_W-1] == '0) || (v[RND_W-1:DATA_W-1] == '1);
    if (fits) begin
      clamp = {1'b0, v[DATA_W-1:0]};
    end else begin
      clamp = {1'b1, (v[RND_W-1] ? SAT_MIN : SAT_MAX)};
    end
  endfunction

  state_e state_q, state_d;

  // input word fields
  mode_e                     in_mode;
  logic [MAT_AW-1:0]         in_idx;
  logic signed [DATA_W-1:0]  in_val;
  logic signed [DATA_W-1:0]  in_vec [3];
  logic                      in_acc;
  logic                      fwd_we, inv_we;

  assign in_mode   = mode_e'(s_axis_tuser_i);
  assign in_idx    = s_axis_tdata_i[MAT_AW-1:0];
  assign in_val    = s_axis_tdata_i[MAT_AW +: DATA_W];
  assign in_vec[0] = s_axis_tdata_i[MAT_AW + DATA_W +: DATA_W];
  assign in_vec[1] = s_axis_tdata_i[MAT_AW + 2 * DATA_W +: DATA_W];
  assign in_vec[2] = s_axis_tdata_i[MAT_AW + 3 * DATA_W +: DATA_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign fwd_we = in_acc && (in_mode == MODE_WR_FWD);
  // drop inverse writes outside the upper 3x3
  assign inv_we = in_acc && (in_mode == MODE_WR_INV) &&
                  (in_idx[3:2] != INV_DIM) && (in_idx[1:0] != INV_DIM);

  // matrix store
  logic [MAT_DEPTH-1:0]     fwd_vld_q, inv_vld_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     iss_vld;
  logic [1:0]               iss_i, iss_k;
  logic [DATA_W-1:0]        fwd_rdata, inv_rdata;

  assign iss_vld = (state_q == ST_MAC) && !cnt_q[CNT_W-1];
  assign iss_i   = cnt_q[3:2];
  assign iss_k   = cnt_q[1:0];

  vtx_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (in_idx),
    .wdata_i (in_val),
    .raddr_i ({iss_k, iss_i}),
    .rdata_o (fwd_rdata)
  );

  vtx_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (in_idx),
    .wdata_i (in_val),
    .raddr_i ({iss_i, iss_k}),
    .rdata_o (inv_rdata)
  );

  // item and pipeline registers
  logic                      is_dir_q;
  logic signed [DATA_W-1:0]  vec_q [3];
  logic                      t1_vld_q, t2_vld_q;
  logic [1:0]                t1_i_q, t1_k_q, t2_i_q, t2_k_q;
  logic signed [PROD_W-1:0]  mul_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [RND_W-1:0]   res_q [4];
  logic [RND_W-1:0]          mg_q [3];
  logic [PROD_W-1:0]         sq_v_q, sq_r_q;
  logic [1:0]                cidx_q;
  logic [DATA_W-1:0]         ox_q [3];
  logic                      degen_q, sat_q;
  logic                      m_vld_q;
  logic [OUT_TDATA_W-1:0]    m_data_q;
  logic [1:0]                m_user_q;

  // stage one: coefficient and operand into the multiplier
  logic                      coef_vld;
  logic signed [DATA_W-1:0]  coef, opnd, mul_a, mul_b;
  logic [1:0]                sel;
  logic [RND_W-1:0]          mg_sel;
  logic                      mul_en;

  always_comb begin
    coef_vld = is_dir_q ? inv_vld_q[{t1_i_q, t1_k_q}] : fwd_vld_q[{t1_k_q, t1_i_q}];
    if (coef_vld) begin
      coef = is_dir_q ? inv_rdata : fwd_rdata;
    end else begin
      coef = (t1_i_q == t1_k_q) ? ONE_Q : '0;
    end
    case (t1_k_q)
      2'd0:    opnd = vec_q[0];
      2'd1:    opnd = vec_q[1];
      2'd2:    opnd = vec_q[2];
      default: opnd = is_dir_q ? '0 : ONE_Q;
    endcase
    sel = (state_q == ST_SQ) ? cnt_q[1:0] : cidx_q;
    case (sel)
      2'd0:    mg_sel = mg_q[0];
      2'd1:    mg_sel = mg_q[1];
      2'd2:    mg_sel = mg_q[2];
      default: mg_sel = '0;
    endcase
    if (state_q == ST_SQ) begin
      mul_a = DATA_W'(mg_sel);
      mul_b = DATA_W'(mg_sel);
    end else begin
      mul_a = coef;
      mul_b = opnd;
    end
    mul_en = t1_vld_q || ((state_q == ST_SQ) && (cnt_q != SQ_LAST));
  end

  // stage two: accumulate with the rounding half preloaded
  logic signed [ACC_W-1:0] mac_sum, sq_sum;
  assign mac_sum = ((t2_k_q == 2'd0) ? HALF_ACC : acc_q) + ACC_W'(mul_q);
  assign sq_sum  = ((cnt_q == CNT_W'(1)) ? ACC_W'(0) : acc_q) + ACC_W'(mul_q);

  // post-accumulation checks
  logic             w_zero, dir_zero;
  logic [DATA_W:0]  cl [3];
  logic [RND_W-1:0] mx01, mx;
  logic             norm_dn, norm_up;

  always_comb begin
    w_zero   = (res_q[3] == '0);
    dir_zero = (res_q[0] == '0) && (res_q[1] == '0) && (res_q[2] == '0);
    for (int i = 0; i < 3; i++) begin
      cl[i] = clamp(res_q[i]);
    end
    mx01    = (mg_q[0] > mg_q[1]) ? mg_q[0] : mg_q[1];
    mx      = (mx01 > mg_q[2]) ? mx01 : mg_q[2];
    norm_dn = |mx[RND_W-1:NORM_TOP];
    norm_up = ~|mx[RND_W-1:NORM_TOP-1];
  end

  // square root step
  logic [PROD_W-1:0] sq_bit, sq_rb;
  logic              sq_take;
  assign sq_bit  = PROD_W'(1) << {cnt_q, 1'b0};
  assign sq_rb   = sq_r_q + sq_bit;
  assign sq_take = (sq_v_q >= sq_rb);

  // divide set-up and result
  logic signed [RND_W-1:0] res_sel;
  logic [RND_W-1:0]        num_mag, den_mag;
  logic [DATA_W-1:0]       len;
  logic [ACC_W:0]          pt_dvd, dir_dvd, dvd;
  logic                    div_ovf, neg_pt;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic [DATA_W:0]         m_sum;
  logic [DATA_W-1:0]       m_val, pt_val, dir_val, ovf_val;
  logic                    pt_sat;

  always_comb begin
    res_sel  = res_q[cidx_q];
    num_mag  = mag(res_sel);
    den_mag  = mag(res_q[3]);
    len      = sq_r_q[DATA_W-1:0];
    pt_dvd   = {num_mag, (FRAC_BITS + 1)'(0)};
    dir_dvd  = {1'b0, mg_sel, FRAC_BITS'(0)} + (ACC_W + 1)'(len >> 1);
    dvd      = is_dir_q ? dir_dvd : pt_dvd;
    div_ovf  = RND_W'(dvd[ACC_W:DATA_W]) >= den_mag;
    neg_pt   = res_sel[RND_W-1] ^ res_q[3][RND_W-1];
    ovf_val  = neg_pt ? SAT_MIN : SAT_MAX;
    m_sum    = {1'b0, div_rsp.quo} + (DATA_W + 1)'(1);
    m_val    = m_sum[DATA_W:1];
    pt_sat   = !neg_pt && m_val[DATA_W-1];
    if (neg_pt) begin
      pt_val = -m_val;
    end else begin
      pt_val = pt_sat ? SAT_MAX : m_val;
    end
    dir_val  = res_sel[RND_W-1] ? -div_rsp.quo : div_rsp.quo;
  end

  vtx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d     = state_q;
    div_req     = '0;
    div_req.hi  = dvd[ACC_W:DATA_W];
    div_req.lo  = dvd[DATA_W-1:0];
    div_req.den = is_dir_q ? RND_W'(len) : den_mag;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && ((in_mode == MODE_POINT) || (in_mode == MODE_DIR))) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (t2_vld_q && (t2_i_q == LAST_ROW) && (t2_k_q == K_BIAS)) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (is_dir_q) begin
          state_d = dir_zero ? ST_OUT : ST_NORM;
        end else begin
          state_d = w_zero ? ST_OUT : ST_DSTART;
        end
      end
      ST_NORM: begin
        if (!norm_dn && !norm_up) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_q == SQ_LAST) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_q == '0) begin
          state_d = ST_DSTART;
        end
      end
      ST_DSTART: begin
        if (is_dir_q || !div_ovf) begin
          div_req.start = 1'b1;
          state_d       = ST_DWAIT;
        end else if (cidx_q == LAST_COMP) begin
          state_d = ST_OUT;
        end
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = (cidx_q == LAST_COMP) ? ST_OUT : ST_DSTART;
        end
      end
      ST_OUT: begin
        if (!m_vld_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fwd_vld_q <= '0;
      inv_vld_q <= '0;
      cnt_q     <= '0;
      cidx_q    <= '0;
      t1_vld_q  <= 1'b0;
      t2_vld_q  <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      t1_vld_q <= iss_vld;
      t2_vld_q <= t1_vld_q;
      if (fwd_we) begin
        fwd_vld_q[in_idx] <= 1'b1;
      end
      if (inv_we) begin
        inv_vld_q[in_idx] <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: cnt_q <= '0;
        ST_MAC: begin
          if (iss_vld) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CHK:  cidx_q <= '0;
        ST_NORM: cnt_q <= '0;
        ST_SQ: begin
          cnt_q <= (cnt_q == SQ_LAST) ? SQRT_LAST : cnt_q + 1'b1;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q - 1'b1;
          cidx_q <= '0;
        end
        ST_DSTART: begin
          if (!is_dir_q && div_ovf) begin
            cidx_q <= cidx_q + 1'b1;
          end
        end
        ST_DWAIT: begin
          if (div_rsp.done) begin
            cidx_q <= cidx_q + 1'b1;
          end
        end
        default: cnt_q <= cnt_q;
      endcase
      if ((state_q == ST_OUT) && (!m_vld_q || m_axis_tready_i)) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    t1_i_q <= iss_i;
    t1_k_q <= iss_k;
    t2_i_q <= t1_i_q;
    t2_k_q <= t1_k_q;
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    if (t2_vld_q) begin
      acc_q <= mac_sum;
      if (t2_k_q == K_BIAS) begin
        res_q[t2_i_q] <= mac_sum[ACC_W-1:FRAC_BITS];
      end
    end else if ((state_q == ST_SQ) && (cnt_q != '0)) begin
      acc_q <= sq_sum;
    end
    if (in_acc) begin
      is_dir_q <= (in_mode == MODE_DIR);
      vec_q    <= in_vec;
      degen_q  <= 1'b0;
      sat_q    <= 1'b0;
    end
    if (state_q == ST_CHK) begin
      if (is_dir_q) begin
        for (int i = 0; i < 3; i++) begin
          mg_q[i] <= mag(res_q[i]);
          ox_q[i] <= '0;
        end
        degen_q <= dir_zero;
      end else if (w_zero) begin
        for (int i = 0; i < 3; i++) begin
          ox_q[i] <= cl[i][DATA_W-1:0];
        end
        degen_q <= 1'b1;
        sat_q   <= cl[0][DATA_W] | cl[1][DATA_W] | cl[2][DATA_W];
      end
    end
    if (state_q == ST_NORM) begin
      // truncate on the way down, keep all bits on the way up
      for (int i = 0; i < 3; i++) begin
        if (norm_dn) begin
          mg_q[i] <= mg_q[i] >> 1;
        end else if (norm_up) begin
          mg_q[i] <= mg_q[i] << 1;
        end
      end
    end
    if ((state_q == ST_SQ) && (cnt_q == SQ_LAST)) begin
      sq_v_q <= sq_sum[PROD_W-1:0];
      sq_r_q <= '0;
    end
    if (state_q == ST_SQRT) begin
      if (sq_take) begin
        sq_v_q <= sq_v_q - sq_rb;
        sq_r_q <= (sq_r_q >> 1) + sq_bit;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
    end
    if ((state_q == ST_DSTART) && !is_dir_q && div_ovf) begin
      ox_q[cidx_q] <= ovf_val;
      sat_q        <= 1'b1;
    end
    if ((state_q == ST_DWAIT) && div_rsp.done) begin
      if (is_dir_q) begin
        ox_q[cidx_q] <= dir_val;
      end else begin
        ox_q[cidx_q] <= pt_val;
        if (pt_sat) begin
          sat_q <= 1'b1;
        end
      end
    end
    if ((state_q == ST_OUT) && (!m_vld_q || m_axis_tready_i)) begin
      m_data_q <= OUT_TDATA_W'({ox_q[2], ox_q[1], ox_q[0]});
      m_user_q <= {sat_q, degen_q};
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && !m_axis_tready_i) |=> (m_vld_q && $stable(m_data_q) && $stable(m_user_q)))
    else $error("result word changed while stalled");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!t1_vld_q && !t2_vld_q))
    else $error("input accepted with products in flight");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> (!norm_dn && !norm_up))
    else $error("largest magnitude out of range before squaring");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DSTART) && is_dir_q) |-> (len != '0))
    else $error("zero length reached the divider");

endmodule

`default_nettype wire

### hdl/vtx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vtx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/vtx_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module vtx_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtx_pkg::div_req_t  req_i,
  output vtx_pkg::div_rsp_t  rsp_o
);

  import vtx_pkg::*;

  logic [RND_W:0]      rem_q, rem_d;
  logic [RND_W-1:0]    den_q, den_d;
  logic [DATA_W-1:0]   quo_q, quo_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [RND_W:0]      trial;
  logic [RND_W:0]      diff;

  always_comb begin
    trial  = {rem_q[RND_W-1:0], quo_q[DATA_W-1]};
    diff   = trial - {1'b0, den_q};
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = (RND_W + 1)'(req_i.hi);
      den_d  = req_i.den;
      quo_d  = req_i.lo;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff;
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == QCNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("divider finished without done");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < {1'b0, den_q}))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire
